// File: hw/rtl/vcc_pkg.sv
`default_nettype none

package vcc_pkg;

  // width of the stock and credit counters
  localparam int unsigned COUNT_BITS = 8;
  // width of the amount and count fields on the channels
  localparam int unsigned FIELD_BITS = 8;
  localparam int unsigned PIN_BITS   = 17;
  // wide enough for a saturating add and compares of a count and an amount
  localparam int unsigned WIDE_BITS  =
      ((COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS) + 1;

  localparam logic [PIN_BITS-1:0]   PIN_RESET = PIN_BITS'(54321);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [WIDE_BITS-1:0]  wide_t;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_SELECT = 3'd1,
    OP_REJECT = 3'd2,
    OP_STOCK  = 3'd3,
    OP_DISP   = 3'd4,
    OP_PIN    = 3'd5,
    OP_EXIT   = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    MODE_EMPTY    = 3'd0,
    MODE_NOCREDIT = 3'd1,
    MODE_CREDIT   = 3'd2,
    MODE_DISPENSE = 3'd3,
    MODE_MAINT    = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_REFUSED  = 3'd1,
    ST_BADPIN   = 3'd2,
    ST_NOSTOCK  = 3'd3,
    ST_NOCREDIT = 3'd4
  } status_e;

  // one input event
  typedef struct packed {
    logic [2:0]            operation;
    logic [FIELD_BITS-1:0] amount;
    logic [PIN_BITS-1:0]   pin_code;
  } item_t;

  // controller state
  typedef struct packed {
    mode_e  mode;
    count_t stock;
    count_t credit;
  } state_t;

  // one result
  typedef struct packed {
    logic [2:0]            status;
    logic [2:0]            mode;
    logic [FIELD_BITS-1:0] stock_count;
    logic [FIELD_BITS-1:0] credit_count;
  } result_t;

  // low field bits of a count, zero filled when the count is narrower
  function automatic logic [FIELD_BITS-1:0] count_to_field(count_t c);
    logic [FIELD_BITS-1:0] r;
    r = '0;
    for (int unsigned i = 0; i < FIELD_BITS; i++) begin
      if (i < COUNT_BITS) begin
        r[i] = c[i];
      end
    end
    return r;
  endfunction

  // saturating add of an amount to a count
  function automatic count_t sat_add(count_t c, logic [FIELD_BITS-1:0] a);
    wide_t s;
    s = WIDE_BITS'(c) + WIDE_BITS'(a);
    return (s > WIDE_BITS'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(s);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/vcc_if.sv
`default_nettype none

// event channel
interface vcc_item_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    operation;
  logic [vcc_pkg::FIELD_BITS-1:0] amount;
  logic [vcc_pkg::PIN_BITS-1:0]   pin_code;

  modport source (output valid, output operation, output amount, output pin_code,
                  input ready);
  modport sink   (input valid, input operation, input amount, input pin_code,
                  output ready);
endinterface

// result channel
interface vcc_result_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [2:0]                    mode;
  logic [vcc_pkg::FIELD_BITS-1:0] stock_count;
  logic [vcc_pkg::FIELD_BITS-1:0] credit_count;

  modport source (output valid, output status, output mode, output stock_count,
                  output credit_count, input ready);
  modport sink   (input valid, input status, input mode, input stock_count,
                  input credit_count, output ready);
endinterface

// pin write channel
interface vcc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [vcc_pkg::PIN_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/vending_credit_controller.sv
`default_nettype none

// channel   dir  payload                                         role
// item_i    in   operation[2:0] amount[7:0] pin_code[16:0]       event to apply
// result_o  out  status[2:0] mode[2:0] stock_count credit_count  outcome of event
// cfg_i     in   data[16:0]                                      maintenance pin
//
// one event per cycle sustained while results are taken: an event waits in
// the input register, then the mode/count update and the result register
// load together. result valid rises when the result register loads the event.
// reset: out of stock, zero counts, pin 54321; no clearing pass.
// a stalled result holds the result register and, one event later, the input
// register; the pin channel is always ready.
module vending_credit_controller (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  vcc_item_if.sink   item_i,
  vcc_result_if.source result_o,
  vcc_cfg_if.sink    cfg_i
);

  vcc_pkg::item_t                in_item;
  vcc_pkg::item_t                held_item;
  logic                          held_valid;
  logic                          advance;
  logic                          out_valid_q, out_valid_d;
  vcc_pkg::result_t              res_q;
  vcc_pkg::state_t               state_q;
  vcc_pkg::state_t               state_d;
  vcc_pkg::status_e              status_next;
  logic [vcc_pkg::PIN_BITS-1:0]  pin_q;
  logic                          load;

  assign in_item.operation = item_i.operation;
  assign in_item.amount    = item_i.amount;
  assign in_item.pin_code  = item_i.pin_code;

  // the result register frees up when empty or taken this cycle
  assign advance = !out_valid_q || result_o.ready;
  assign load    = advance && held_valid;

  // input register
  vcc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (item_i.valid),
    .ready_o   (item_i.ready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  // event decode and count update
  vcc_step u_step (
    .state_i  (state_q),
    .item_i   (held_item),
    .pin_i    (pin_q),
    .state_o  (state_d),
    .status_o (status_next)
  );

  // pin register, written on transfer
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q <= vcc_pkg::PIN_RESET;
    end else if (cfg_i.valid) begin
      pin_q <= cfg_i.data;
    end
  end

  // mode and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode   <= vcc_pkg::MODE_EMPTY;
      state_q.stock  <= '0;
      state_q.credit <= '0;
    end else if (load) begin
      state_q <= state_d;
    end
  end

  // result valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = held_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q.status       <= status_next;
      res_q.mode         <= state_d.mode;
      res_q.stock_count  <= vcc_pkg::count_to_field(state_d.stock);
      res_q.credit_count <= vcc_pkg::count_to_field(state_d.credit);
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.status       = res_q.status;
  assign result_o.mode         = res_q.mode;
  assign result_o.stock_count  = res_q.stock_count;
  assign result_o.credit_count = res_q.credit_count;

`ifndef SYNTHESIS
  // a refused event leaves mode and counts alone
  a_refused_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && status_next == vcc_pkg::ST_REFUSED) |=>
      (state_q.mode == $past(state_q.mode) && state_q.stock == $past(state_q.stock) &&
       state_q.credit == $past(state_q.credit)))
    else $error("refused event changed state");

  // a pending result always shows the current mode
  a_result_tracks_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.mode == state_q.mode))
    else $error("result mode differs from held mode");

  // dispensing is entered only by a select
  a_dispense_from_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && state_d.mode == vcc_pkg::MODE_DISPENSE &&
     state_q.mode != vcc_pkg::MODE_DISPENSE) |-> (held_item.operation == vcc_pkg::OP_SELECT))
    else $error("dispensing entered without select");

  // maintenance is entered only from out of stock or no credit
  a_maint_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && state_d.mode == vcc_pkg::MODE_MAINT && state_q.mode != vcc_pkg::MODE_MAINT)
      |-> (state_q.mode == vcc_pkg::MODE_EMPTY || state_q.mode == vcc_pkg::MODE_NOCREDIT))
    else $error("maintenance entered from wrong mode");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/vcc_in_stage.sv
`default_nettype none

module vcc_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output      logic           ready_o,
  input  wire vcc_pkg::item_t item_i,
  input  wire logic           advance_i,
  output      logic           valid_o,
  output      vcc_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  vcc_pkg::item_t item_q;

  // take a new event when none is held or whenever the held one moves on this cycle
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, loaded on transfer
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// File: hw/rtl/vcc_step.sv
`default_nettype none

module vcc_step (
  input  wire vcc_pkg::state_t             state_i,
  input  wire vcc_pkg::item_t              item_i,
  input  wire logic [vcc_pkg::PIN_BITS-1:0] pin_i,
  output      vcc_pkg::state_t             state_o,
  output      vcc_pkg::status_e            status_o
);

  vcc_pkg::wide_t stock_w;
  vcc_pkg::wide_t credit_w;
  vcc_pkg::wide_t amount_w;

  assign stock_w  = vcc_pkg::WIDE_BITS'(state_i.stock);
  assign credit_w = vcc_pkg::WIDE_BITS'(state_i.credit);
  assign amount_w = vcc_pkg::WIDE_BITS'(item_i.amount);

  // event decode against the current mode
  always_comb begin
    state_o  = state_i;
    status_o = vcc_pkg::ST_REFUSED;
    unique case (item_i.operation)
      vcc_pkg::OP_INSERT: begin
        if (state_i.mode == vcc_pkg::MODE_NOCREDIT || state_i.mode == vcc_pkg::MODE_CREDIT) begin
          state_o.credit = vcc_pkg::sat_add(state_i.credit, item_i.amount);
          state_o.mode   = vcc_pkg::MODE_CREDIT;
          status_o       = vcc_pkg::ST_DONE;
        end
      end
      vcc_pkg::OP_SELECT: begin
        if (state_i.mode == vcc_pkg::MODE_CREDIT) begin
          if (stock_w < amount_w) begin
            status_o = vcc_pkg::ST_NOSTOCK;
          end else if (credit_w < amount_w) begin
            status_o = vcc_pkg::ST_NOCREDIT;
          end else begin
            state_o.stock  = vcc_pkg::COUNT_BITS'(stock_w - amount_w);
            state_o.credit = vcc_pkg::COUNT_BITS'(credit_w - amount_w);
            state_o.mode   = vcc_pkg::MODE_DISPENSE;
            status_o       = vcc_pkg::ST_DONE;
          end
        end
      end
      vcc_pkg::OP_REJECT: begin
        if (state_i.mode == vcc_pkg::MODE_CREDIT) begin
          state_o.credit = '0;
          state_o.mode   = vcc_pkg::MODE_NOCREDIT;
          status_o       = vcc_pkg::ST_DONE;
        end
      end
      vcc_pkg::OP_STOCK: begin
        if (state_i.mode == vcc_pkg::MODE_MAINT) begin
          state_o.stock = vcc_pkg::sat_add(state_i.stock, item_i.amount);
          status_o      = vcc_pkg::ST_DONE;
        end
      end
      vcc_pkg::OP_DISP: begin
        if (state_i.mode == vcc_pkg::MODE_DISPENSE) begin
          if (state_i.stock == '0) begin
            state_o.mode = vcc_pkg::MODE_EMPTY;
          end else if (state_i.credit == '0) begin
            state_o.mode = vcc_pkg::MODE_NOCREDIT;
          end else begin
            state_o.mode = vcc_pkg::MODE_CREDIT;
          end
          status_o = vcc_pkg::ST_DONE;
        end
      end
      vcc_pkg::OP_PIN: begin
        if (state_i.mode == vcc_pkg::MODE_EMPTY || state_i.mode == vcc_pkg::MODE_NOCREDIT) begin
          if (item_i.pin_code == pin_i) begin
            state_o.mode = vcc_pkg::MODE_MAINT;
            status_o     = vcc_pkg::ST_DONE;
          end else begin
            status_o = vcc_pkg::ST_BADPIN;
          end
        end
      end
      vcc_pkg::OP_EXIT: begin
        if (state_i.mode == vcc_pkg::MODE_MAINT) begin
          state_o.mode = (state_i.stock == '0) ? vcc_pkg::MODE_EMPTY : vcc_pkg::MODE_NOCREDIT;
          status_o     = vcc_pkg::ST_DONE;
        end
      end
      default: begin
        status_o = vcc_pkg::ST_REFUSED;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: test/vending_credit_checker.sv
`default_nettype none

module vending_credit_checker
  import vcc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vcc_item_if       item_mon,
  vcc_result_if     result_mon,
  vcc_cfg_if        cfg_mon,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the controller state and its pin register
  mode_e               mode_q;
  count_t              stock_q;
  count_t              credit_q;
  logic [PIN_BITS-1:0] pin_q;

  // outcomes predicted for accepted events, oldest first
  result_t outcome_q[$];
  result_t want_r;
  result_t got_r;

  // count plus amount, held at the counter maximum
  function automatic count_t add_capped(count_t c, logic [FIELD_BITS-1:0] a);
    longint unsigned s;
    s = c;
    s += a;
    return (s > COUNT_MAX) ? COUNT_MAX : count_t'(s);
  endfunction

  // apply one event to the shadow state, return the outcome it reports
  function automatic result_t apply_event(logic [2:0] op, logic [FIELD_BITS-1:0] amt,
                                          logic [PIN_BITS-1:0] code);
    status_e st;
    result_t r;
    st = ST_REFUSED;
    case (op)
      OP_INSERT: begin
        if (mode_q == MODE_NOCREDIT || mode_q == MODE_CREDIT) begin
          credit_q = add_capped(credit_q, amt);
          mode_q   = MODE_CREDIT;
          st       = ST_DONE;
        end
      end
      OP_SELECT: begin
        // stock is checked before credit
        if (mode_q == MODE_CREDIT) begin
          if (stock_q < amt) begin
            st = ST_NOSTOCK;
          end else if (credit_q < amt) begin
            st = ST_NOCREDIT;
          end else begin
            stock_q  = stock_q - count_t'(amt);
            credit_q = credit_q - count_t'(amt);
            mode_q   = MODE_DISPENSE;
            st       = ST_DONE;
          end
        end
      end
      OP_REJECT: begin
        if (mode_q == MODE_CREDIT) begin
          credit_q = '0;
          mode_q   = MODE_NOCREDIT;
          st       = ST_DONE;
        end
      end
      OP_STOCK: begin
        if (mode_q == MODE_MAINT) begin
          stock_q = add_capped(stock_q, amt);
          st      = ST_DONE;
        end
      end
      OP_DISP: begin
        if (mode_q == MODE_DISPENSE) begin
          if (stock_q == '0) begin
            mode_q = MODE_EMPTY;
          end else if (credit_q == '0) begin
            mode_q = MODE_NOCREDIT;
          end else begin
            mode_q = MODE_CREDIT;
          end
          st = ST_DONE;
        end
      end
      OP_PIN: begin
        if (mode_q == MODE_EMPTY || mode_q == MODE_NOCREDIT) begin
          if (code == pin_q) begin
            mode_q = MODE_MAINT;
            st     = ST_DONE;
          end else begin
            st = ST_BADPIN;
          end
        end
      end
      OP_EXIT: begin
        if (mode_q == MODE_MAINT) begin
          mode_q = (stock_q == '0) ? MODE_EMPTY : MODE_NOCREDIT;
          st     = ST_DONE;
        end
      end
      // the unused code is refused like any misplaced event
      default: begin
        st = ST_REFUSED;
      end
    endcase
    r.status       = st;
    r.mode         = mode_q;
    r.stock_count  = FIELD_BITS'(stock_q);
    r.credit_count = FIELD_BITS'(credit_q);
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
    fail_count_o++;
  endtask

  // result transfers are checked before the same edge's event is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       = MODE_EMPTY;
      stock_q      = '0;
      credit_q     = '0;
      pin_q        = PIN_RESET;
      outcome_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      // result transfer
      if (result_mon.valid && result_mon.ready) begin
        got_r.status       = result_mon.status;
        got_r.mode         = result_mon.mode;
        got_r.stock_count  = result_mon.stock_count;
        got_r.credit_count = result_mon.credit_count;
        if (outcome_q.size() == 0) begin
          $display("%0t: result with nothing pending, got status %0h mode %0h %s",
                   $time, got_r.status, got_r.mode,
                   $sformatf("stock %0h credit %0h", got_r.stock_count,
                             got_r.credit_count));
          fail_count_o++;
        end else begin
          want_r = outcome_q.pop_front();
          if (got_r.status !== want_r.status) begin
            note_mismatch("status", 8'(want_r.status), 8'(got_r.status));
          end
          if (got_r.mode !== want_r.mode) begin
            note_mismatch("mode", 8'(want_r.mode), 8'(got_r.mode));
          end
          if (got_r.stock_count !== want_r.stock_count) begin
            note_mismatch("stock_count", 8'(want_r.stock_count), 8'(got_r.stock_count));
          end
          if (got_r.credit_count !== want_r.credit_count) begin
            note_mismatch("credit_count", 8'(want_r.credit_count),
                          8'(got_r.credit_count));
          end
          checked_o++;
        end
      end
      // pin write transfer
      if (cfg_mon.valid && cfg_mon.ready) begin
        pin_q = cfg_mon.data;
      end
      // event transfer, appended at the tail
      if (item_mon.valid && item_mon.ready) begin
        outcome_q.insert(outcome_q.size(),
                         apply_event(item_mon.operation, item_mon.amount,
                                     item_mon.pin_code));
      end
      pending_o = outcome_q.size();
    end
  end

endmodule

`default_nettype wire

// File: test/vending_credit_controller_tb.sv
`default_nettype none

module vending_credit_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vcc_pkg::*;

  localparam logic [2:0]          OP_UNUSED    = 3'd7;
  localparam logic [PIN_BITS-1:0] PIN_LOW      = '0;
  localparam logic [PIN_BITS-1:0] PIN_HIGH     = PIN_BITS'(99999);
  localparam logic [PIN_BITS-1:0] PIN_ALL_ONES = '1;
  localparam int unsigned         PHASE_ITEMS  = 270;

  logic clk_i;
  logic rst_ni;

  vcc_item_if   event_ch ();
  vcc_result_if outcome_ch ();
  vcc_cfg_if    pin_ch ();

  int                  fail_count;
  int                  pending;
  int                  checked;
  int                  sent;
  int                  pin_writes;
  bit                  tx_steady;
  bit                  rx_steady;
  logic [PIN_BITS-1:0] active_pin;

  vending_credit_controller dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (event_ch),
    .result_o (outcome_ch),
    .cfg_i    (pin_ch)
  );

  vending_credit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_mon     (event_ch),
    .result_mon   (outcome_ch),
    .cfg_mon      (pin_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // mostly small so the counts move both ways, now and then anything
  function automatic logic [FIELD_BITS-1:0] pick_amount();
    if ($urandom_range(0, 4) == 0) begin
      return FIELD_BITS'($urandom());
    end
    return FIELD_BITS'($urandom_range(0, 40));
  endfunction

  // one event transfer, after a random gap unless in a steady stretch
  task automatic send_event(input logic [2:0] op, input logic [FIELD_BITS-1:0] amt,
                            input logic [PIN_BITS-1:0] code);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap != 0) begin
      event_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    event_ch.operation = op;
    event_ch.amount    = amt;
    event_ch.pin_code  = code;
    event_ch.valid     = 1'b1;
    do @(posedge clk_i); while (!event_ch.ready);
    sent++;
  endtask

  // stop sending and wait until every outcome has come back
  task automatic settle();
    @(negedge clk_i);
    event_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // pin register write, only while the block is idle
  task automatic write_pin(input logic [PIN_BITS-1:0] code);
    @(negedge clk_i);
    pin_ch.data  = code;
    pin_ch.valid = 1'b1;
    do @(posedge clk_i); while (!pin_ch.ready);
    @(negedge clk_i);
    pin_ch.valid = 1'b0;
    active_pin   = code;
    pin_writes++;
  endtask

  // result side: random stall after each transfer, unless in a steady stretch
  initial begin
    int unsigned hold;
    hold = 0;
    outcome_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        outcome_ch.ready = 1'b0;
        hold--;
      end else begin
        outcome_ch.ready = 1'b1;
      end
      @(posedge clk_i);
      if (outcome_ch.valid && outcome_ch.ready) begin
        hold = rx_steady ? 0 : $urandom_range(0, 4);
      end
    end
  end

  // stimulus
  initial begin
    logic [PIN_BITS-1:0] pin_plan [6];
    int unsigned         phase_end;
    int unsigned         r;
    int unsigned         n;
    logic [2:0]          op;

    rst_ni             = 1'b0;
    event_ch.valid     = 1'b0;
    event_ch.operation = OP_INSERT;
    event_ch.amount    = '0;
    event_ch.pin_code  = '0;
    pin_ch.valid       = 1'b0;
    pin_ch.data        = '0;
    tx_steady          = 1'b0;
    rx_steady          = 1'b0;
    sent               = 0;
    pin_writes         = 0;
    active_pin         = PIN_RESET;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed walk through every mode with the reset pin
    send_event(OP_INSERT, 8'hFF, PIN_ALL_ONES);   // refused while out of stock
    send_event(OP_SELECT, 8'h00, PIN_LOW);
    send_event(OP_PIN, 8'h00, PIN_LOW);           // wrong pin
    send_event(OP_PIN, 8'hFF, PIN_ALL_ONES);      // wrong pin, all bits set
    send_event(OP_UNUSED, 8'h55, PIN_RESET);      // unused code
    send_event(OP_PIN, 8'h00, PIN_RESET);         // into maintenance
    send_event(OP_STOCK, 8'h00, PIN_LOW);
    send_event(OP_STOCK, 8'hFF, PIN_LOW);
    send_event(OP_STOCK, 8'h01, PIN_LOW);         // stock saturates
    send_event(OP_INSERT, 8'h10, PIN_LOW);        // refused in maintenance
    send_event(OP_EXIT, 8'h00, PIN_LOW);          // stock left, no credit
    send_event(OP_DISP, 8'h00, PIN_LOW);          // refused
    send_event(OP_INSERT, 8'h00, PIN_LOW);        // zero still gives credit mode
    send_event(OP_INSERT, 8'hFF, PIN_LOW);
    send_event(OP_INSERT, 8'h01, PIN_LOW);        // credit saturates
    send_event(OP_SELECT, 8'd200, PIN_LOW);
    send_event(OP_DISP, 8'h00, PIN_LOW);          // back to credit
    send_event(OP_SELECT, 8'd100, PIN_LOW);       // stock short
    send_event(OP_REJECT, 8'h00, PIN_LOW);
    send_event(OP_INSERT, 8'd10, PIN_LOW);
    send_event(OP_SELECT, 8'd20, PIN_LOW);        // credit short
    send_event(OP_SELECT, 8'd10, PIN_LOW);
    send_event(OP_DISP, 8'h00, PIN_LOW);          // no credit left
    send_event(OP_INSERT, 8'd50, PIN_LOW);
    send_event(OP_SELECT, 8'd45, PIN_LOW);        // takes the last bars
    send_event(OP_DISP, 8'h00, PIN_LOW);          // out of stock
    settle();

    // random phases, each under its own pin, extremes included
    pin_plan = '{PIN_LOW, PIN_HIGH, PIN_BITS'($urandom_range(0, 99999)),
                 PIN_BITS'($urandom_range(0, 99999)), PIN_RESET,
                 PIN_BITS'($urandom_range(0, 99999))};
    foreach (pin_plan[p]) begin
      write_pin(pin_plan[p]);
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) tx_steady = ~tx_steady;
        if ($urandom_range(0, 9) == 0) rx_steady = ~rx_steady;
        r = $urandom_range(0, 99);
        if (r < 45) begin
          // purchase: pay, then pick or take the money back
          n = $urandom_range(1, 3);
          repeat (n) send_event(OP_INSERT, pick_amount(), PIN_BITS'($urandom()));
          r = $urandom_range(0, 9);
          if (r < 2) begin
            send_event(OP_REJECT, pick_amount(), PIN_BITS'($urandom()));
          end else begin
            send_event(OP_SELECT, pick_amount(), PIN_BITS'($urandom()));
            if (r > 2) send_event(OP_DISP, pick_amount(), PIN_BITS'($urandom()));
          end
          if ($urandom_range(0, 1) == 0) begin
            send_event(OP_REJECT, pick_amount(), PIN_BITS'($urandom()));
          end
        end else if (r < 75) begin
          // maintenance visit: mostly the right pin, restock, leave
          send_event(OP_PIN, pick_amount(),
                     ($urandom_range(0, 7) == 0) ? PIN_BITS'($urandom()) : active_pin);
          n = $urandom_range(0, 3);
          repeat (n) send_event(OP_STOCK, pick_amount(), PIN_BITS'($urandom()));
          send_event(OP_EXIT, pick_amount(), PIN_BITS'($urandom()));
        end else begin
          // noise: any code, any amount
          op = 3'($urandom_range(0, OP_UNUSED));
          send_event(op, FIELD_BITS'($urandom()),
                     ($urandom_range(0, 3) == 0) ? active_pin : PIN_BITS'($urandom()));
        end
      end
      settle();
    end

    // let any stray result show up
    repeat (8) @(negedge clk_i);
    $display("covered %0d events under %0d pin settings, %0d outcomes compared",
             sent, pin_writes + 1, checked);
    $display("mismatches and stray results: %0d", fail_count);
    if (fail_count == 0) begin
      $display("vending_credit_controller regression: pass");
    end else begin
      $display("vending_credit_controller regression: fail");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("timeout with %0d outcomes pending", pending);
    $display("vending_credit_controller regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/vcc_pkg.sv
hw/rtl/vcc_if.sv
hw/rtl/vcc_in_stage.sv
hw/rtl/vcc_step.sv
hw/rtl/vending_credit_controller.sv
test/vending_credit_checker.sv
test/vending_credit_controller_tb.sv
